// ===== hdl/popi_pkg.sv =====
// popi_pkg: shared types and constants for the planar odometry pose integrator.
// Holds the front-to-back item, the result record and the sine table generator.
// No dependencies.
package popi_pkg;

  localparam int MID_FIFO_DEPTH = 4;
  localparam int OUT_FIFO_DEPTH = 8;
  localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int ACC_W          = 40;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } popi_quad_t;

  // Classified frame, front -> back
  typedef struct packed {
    logic               first;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [15:0]        rot_heading;  // heading held from the previous frame
    logic signed [15:0] yaw;
  } popi_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] pose_x;
    logic signed [ACC_W-1:0] pose_y;
    logic signed [15:0]      heading;
  } popi_result_t;

  // Q1.15 sine of angle a (Q2.30 radians), Taylor series to the 15th power.
  // Evaluated at elaboration only.
  function automatic logic [14:0] sine_q15(input logic [63:0] a);
    logic [63:0]        a2;
    logic [63:0]        term;
    logic signed [63:0] s;
    logic signed [63:0] q;
    a2   = (a * a) >> 30;
    term = a;
    s    = $signed(a);
    term = ((term * a2) >> 30) / 6;
    s    = s - $signed(term);
    term = ((term * a2) >> 30) / 20;
    s    = s + $signed(term);
    term = ((term * a2) >> 30) / 42;
    s    = s - $signed(term);
    term = ((term * a2) >> 30) / 72;
    s    = s + $signed(term);
    term = ((term * a2) >> 30) / 110;
    s    = s - $signed(term);
    term = ((term * a2) >> 30) / 156;
    s    = s + $signed(term);
    term = ((term * a2) >> 30) / 210;
    s    = s - $signed(term);
    if (s < 0) begin
      s = 0;
    end
    q = (s * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[14:0];
  endfunction

endpackage

// ===== hdl/planar_odometry_pose_integrator_top.sv =====
// planar_odometry_pose_integrator_top: planar dead-reckoning pose integrator.
// Instantiates popi_front, popi_fifo (twice) and popi_back; depends on popi_pkg.
//
//   channel   handshake            transaction when            payload
//   -------   ------------------   -------------------------   -----------------------------
//   frame in  push / full          push && !full at clk edge   wheel_pos_x, wheel_pos_y, yaw_raw
//   pose out  empty / pop          pop && !empty at clk edge   pose_x, pose_y, heading
//
// Flow: one frame per clock sustained while full stays low. An accepted frame passes the
// front queue and the index, lookup, multiply and round/scale registers, and is accumulated
// as it is written into the result queue.
// Reset: synchronous on rst; sets the first-frame flag, clears pose, heading and both queues.
// Stalls: full rises only when the 4-entry front queue fills. The back part issues
// while the 8-entry result queue has room for everything in its four stages, so a
// stalled pop backs up into the front queue and then into full.
module planar_odometry_pose_integrator_top #(
  parameter int SINE_TABLE_DEPTH   = 256,
  parameter int POSE_FRACTION_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // frame input
  input  logic                               push,
  output logic                               full,
  input  logic signed [15:0]                 wheel_pos_x,
  input  logic signed [15:0]                 wheel_pos_y,
  input  logic signed [15:0]                 yaw_raw,
  // pose output
  output logic                               empty,
  input  logic                               pop,
  output logic signed [popi_pkg::ACC_W-1:0]  pose_x,
  output logic signed [popi_pkg::ACC_W-1:0]  pose_y,
  output logic signed [15:0]                 heading
);
  import popi_pkg::*;

  localparam int ITEM_W = $bits(popi_item_t);
  localparam int RES_W  = $bits(popi_result_t);

  logic                 in_accept;
  popi_item_t           front_item;
  popi_item_t           mid_item;
  logic [ITEM_W-1:0]    mid_dout;
  logic                 mid_empty;
  logic                 mid_pop;
  logic                 res_push;
  logic                 res_full;
  popi_result_t         back_res;
  popi_result_t         out_res;
  logic [RES_W-1:0]     out_dout;
  logic [OUT_CNT_W-1:0] res_count;

  assign in_accept = push && !full;

  // Front: per-frame state, first-frame flag and wheel deltas
  popi_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .wheel_pos_x (wheel_pos_x),
    .wheel_pos_y (wheel_pos_y),
    .yaw_raw     (yaw_raw),
    .item        (front_item)
  );

  // Decoupling queue between front and back
  popi_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_FIFO_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (in_accept),
    .din   (front_item),
    .full  (full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty),
    .count ()
  );

  assign mid_item = popi_item_t'(mid_dout);

  // Back: rotation and pose integration pipeline
  popi_back #(
    .SINE_TABLE_DEPTH   (SINE_TABLE_DEPTH),
    .POSE_FRACTION_BITS (POSE_FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (mid_item),
    .item_empty (mid_empty),
    .item_pop   (mid_pop),
    .res_count  (res_count),
    .res_push   (res_push),
    .res        (back_res)
  );

  // Result queue; head is presented on the pose ports
  popi_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty),
    .count (res_count)
  );

  assign out_res = popi_result_t'(out_dout);
  assign pose_x  = out_res.pose_x;
  assign pose_y  = out_res.pose_y;
  assign heading = out_res.heading;

  // Credit scheme must never push into a full result queue
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full result queue");

  // Any accepted frame clears the first-frame flag
  a_first_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !front_item.first)
    else $error("first-frame flag still set after a transaction");

  // Nothing is waiting right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

// ===== hdl/popi_fifo.sv =====
// popi_fifo: small register FIFO with full/empty/count.
// Used between front and back and for finished results. No package dependency.
module popi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             din,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             dout,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/popi_front.sv =====
// popi_front: takes sensor frames, tracks first frame, previous wheel position
// and heading, and forms the wheel delta item. Depends on popi_pkg.
module popi_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic signed [15:0]     wheel_pos_x,
  input  logic signed [15:0]     wheel_pos_y,
  input  logic signed [15:0]     yaw_raw,
  output popi_pkg::popi_item_t   item
);
  import popi_pkg::*;

  logic               first_frame;
  logic signed [15:0] prev_wheel_x;
  logic signed [15:0] prev_wheel_y;
  logic [15:0]        heading_reg;

  always_comb begin
    item.first       = first_frame;
    item.dx          = 17'(wheel_pos_x) - 17'(prev_wheel_x);
    item.dy          = 17'(wheel_pos_y) - 17'(prev_wheel_y);
    item.rot_heading = heading_reg;
    item.yaw         = yaw_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame  <= 1'b1;
      prev_wheel_x <= '0;
      prev_wheel_y <= '0;
      heading_reg  <= '0;
    end else if (accept) begin
      first_frame  <= 1'b0;
      prev_wheel_x <= wheel_pos_x;
      prev_wheel_y <= wheel_pos_y;
      heading_reg  <= yaw_raw;
    end
  end

endmodule

// ===== hdl/popi_back.sv =====
// popi_back: rotates wheel deltas by the held heading and integrates the pose.
// Stages: index, sine lookup, multiply, round/scale, accumulate. Depends on popi_pkg.
module popi_back #(
  parameter int SINE_TABLE_DEPTH   = 256,
  parameter int POSE_FRACTION_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  popi_pkg::popi_item_t              item,
  input  logic                              item_empty,
  output logic                              item_pop,
  input  logic [popi_pkg::OUT_CNT_W-1:0]    res_count,
  output logic                              res_push,
  output popi_pkg::popi_result_t            res
);
  import popi_pkg::*;

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = 14 + IW + 1;
  localparam int RW = 34;
  localparam int UW = (POSE_FRACTION_BITS > 15) ? RW + POSE_FRACTION_BITS - 15 : RW;
  localparam int SW = ACC_W + 2;

  // quarter-wave table, built at elaboration
  logic [14:0] sine_rom [SINE_TABLE_DEPTH + 1];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] ANG = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    localparam logic [14:0] VAL = sine_q15(ANG);
    assign sine_rom[k] = VAL;
  end

  // stage valids
  logic v1, v2, v3, v4;
  logic [2:0]           inflight;
  logic [OUT_CNT_W:0]   credit_sum;

  assign inflight   = 3'(v1) + 3'(v2) + 3'(v3) + 3'(v4);
  assign credit_sum = (OUT_CNT_W + 1)'(res_count) + (OUT_CNT_W + 1)'(inflight);
  assign item_pop   = !item_empty && (credit_sum < (OUT_CNT_W + 1)'(OUT_FIFO_DEPTH));

  // stage 1: table index
  logic [PW-1:0]      idx_prod;
  logic [IW:0]        idx_raw;
  logic [IW-1:0]      idx;
  logic               first1;
  logic signed [16:0] dx1, dy1;
  logic signed [15:0] yaw1;
  popi_quad_t         quad1;
  logic [IW-1:0]      si1, ci1;

  assign idx_prod = PW'(item.rot_heading[13:0]) * PW'(SINE_TABLE_DEPTH) + PW'(8192);
  assign idx_raw  = idx_prod[PW-1:14];
  assign idx      = (idx_raw > (IW + 1)'(SINE_TABLE_DEPTH)) ?
                    IW'(SINE_TABLE_DEPTH) : idx_raw[IW-1:0];

  always_ff @(posedge clk) begin
    if (item_pop) begin
      first1 <= item.first;
      dx1    <= item.dx;
      dy1    <= item.dy;
      yaw1   <= item.yaw;
      quad1  <= popi_quad_t'(item.rot_heading[15:14]);
      si1    <= idx;
      ci1    <= IW'(SINE_TABLE_DEPTH) - idx;
    end
  end

  // stage 2: sine/cosine lookup
  logic               first2;
  logic signed [16:0] dx2, dy2;
  logic signed [15:0] yaw2;
  popi_quad_t         quad2;
  logic [14:0]        s2, c2;

  always_ff @(posedge clk) begin
    first2 <= first1;
    dx2    <= dx1;
    dy2    <= dy1;
    yaw2   <= yaw1;
    quad2  <= quad1;
    s2     <= sine_rom[si1];
    c2     <= sine_rom[ci1];
  end

  // stage 3: quadrant fold and products
  logic signed [15:0] sn, cs, s_pos, c_pos;
  logic               first3;
  logic signed [15:0] yaw3;
  logic signed [32:0] p_xc, p_ys, p_xs, p_yc;

  assign s_pos = {1'b0, s2};
  assign c_pos = {1'b0, c2};

  always_comb begin
    unique case (quad2)
      QUAD_0: begin
        sn = s_pos;
        cs = c_pos;
      end
      QUAD_1: begin
        sn = c_pos;
        cs = -s_pos;
      end
      QUAD_2: begin
        sn = -s_pos;
        cs = -c_pos;
      end
      QUAD_3: begin
        sn = -c_pos;
        cs = s_pos;
      end
      default: begin
        sn = s_pos;
        cs = c_pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    first3 <= first2;
    yaw3   <= yaw2;
    p_xc   <= dx2 * cs;
    p_ys   <= dy2 * sn;
    p_xs   <= dx2 * sn;
    p_yc   <= dy2 * cs;
  end

  // stage 4: combine and scale to pose units
  logic signed [RW-1:0] rx, ry;
  logic signed [UW-1:0] ux, uy;
  logic                 first4;
  logic signed [15:0]   yaw4;
  logic signed [UW-1:0] ux4, uy4;

  assign rx = RW'(p_xc) - RW'(p_ys);
  assign ry = RW'(p_xs) + RW'(p_yc);

  if (POSE_FRACTION_BITS < 15) begin : g_round
    localparam int SH = 15 - POSE_FRACTION_BITS;
    localparam logic signed [RW-1:0] RND = RW'(1) << (SH - 1);
    // round half up, then arithmetic shift
    assign ux = (rx + RND) >>> SH;
    assign uy = (ry + RND) >>> SH;
  end else if (POSE_FRACTION_BITS > 15) begin : g_scale
    assign ux = UW'(rx) <<< (POSE_FRACTION_BITS - 15);
    assign uy = UW'(ry) <<< (POSE_FRACTION_BITS - 15);
  end else begin : g_same
    assign ux = rx;
    assign uy = ry;
  end

  always_ff @(posedge clk) begin
    first4 <= first3;
    yaw4   <= yaw3;
    ux4    <= ux;
    uy4    <= uy;
  end

  // stage 5: saturating accumulators
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SW-1:0] v);
    logic [2:0] top;
    top = v[SW-1:ACC_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[ACC_W-1:0];
    end
    return v[SW-1] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
  endfunction

  logic signed [ACC_W-1:0] acc_x, acc_y;
  logic signed [ACC_W-1:0] acc_x_next, acc_y_next;

  always_comb begin
    if (first4) begin
      acc_x_next = '0;
      acc_y_next = '0;
    end else begin
      acc_x_next = sat_acc(SW'(acc_x) + SW'(ux4));
      acc_y_next = sat_acc(SW'(acc_y) + SW'(uy4));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (v4) begin
      acc_x <= acc_x_next;
      acc_y <= acc_y_next;
    end
  end

  assign res_push    = v4;
  assign res.pose_x  = acc_x_next;
  assign res.pose_y  = acc_y_next;
  assign res.heading = yaw4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= item_pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

endmodule
